FILE: design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rtalu_pkg.sv
// types and constants of the r-type alu with register file
package rtalu_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 5;
  localparam int REG_COUNT = 2 ** IDX_W;
  localparam int OP_W      = 4;
  localparam int PC_W      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_AND  = 4'd2,
    OP_OR   = 4'd3,
    OP_XOR  = 4'd4,
    OP_NOR  = 4'd5,
    OP_NAND = 4'd6,
    OP_SLT  = 4'd7,
    OP_SLL  = 4'd8,
    OP_SRL  = 4'd9,
    OP_SRA  = 4'd10,
    OP_JR   = 4'd11
  } alu_op_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              write_en;
    logic              overflow;
    logic              zero_write;
    logic              jump;
  } exec_res_t;

endpackage

FILE: design/rtalu_ram.sv
// generic ram, one write port, two registered read ports
module rtalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/rtalu_regfile.sv
// register file: ram, per-entry valid bits and write bypass
`include "assert_macros.svh"
module rtalu_regfile (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [rtalu_pkg::IDX_W-1:0]    rd_addr_a,
  input  logic [rtalu_pkg::IDX_W-1:0]    rd_addr_b,
  input  rtalu_pkg::rf_wr_t              wr,
  output logic [rtalu_pkg::DATA_W-1:0]   rd_data_a,
  output logic [rtalu_pkg::DATA_W-1:0]   rd_data_b
);

  logic [rtalu_pkg::REG_COUNT-1:0] valid_r;
  logic                            fwd_a_r;
  logic                            fwd_b_r;
  logic                            val_a_r;
  logic                            val_b_r;
  logic [rtalu_pkg::DATA_W-1:0]    fwd_data_r;
  logic [rtalu_pkg::DATA_W-1:0]    ram_a;
  logic [rtalu_pkg::DATA_W-1:0]    ram_b;

  rtalu_ram #(
    .WIDTH (rtalu_pkg::DATA_W),
    .DEPTH (rtalu_pkg::REG_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (rd_en),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // a write landing on the read edge is taken from the bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_a_r    <= wr.en && (wr.addr == rd_addr_a);
      fwd_b_r    <= wr.en && (wr.addr == rd_addr_b);
      val_a_r    <= valid_r[rd_addr_a];
      val_b_r    <= valid_r[rd_addr_b];
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data_a = fwd_a_r ? fwd_data_r : (val_a_r ? ram_a : '0);
  assign rd_data_b = fwd_b_r ? fwd_data_r : (val_b_r ? ram_b : '0);

  `ASSERT_IMPLIES(a_no_zero_write, wr.en, wr.addr != '0, "write to register zero")

endmodule

FILE: design/rtalu_exec.sv
// alu operations, write decision and program counter update
module rtalu_exec (
  input  logic [rtalu_pkg::OP_W-1:0]   op_sel,
  input  logic [rtalu_pkg::IDX_W-1:0]  dest,
  input  logic [rtalu_pkg::IDX_W-1:0]  shamt,
  input  logic [rtalu_pkg::DATA_W-1:0] a,
  input  logic [rtalu_pkg::DATA_W-1:0] b,
  input  logic [rtalu_pkg::PC_W-1:0]   pc,
  output rtalu_pkg::exec_res_t         res,
  output logic [rtalu_pkg::PC_W-1:0]   pc_nxt
);

  localparam int MSB = rtalu_pkg::DATA_W - 1;

  logic [rtalu_pkg::DATA_W-1:0] sum_v;
  logic [rtalu_pkg::DATA_W-1:0] diff_v;

  assign sum_v  = a + b;
  assign diff_v = a - b;

  always_comb begin
    logic alu;
    alu            = 1'b1;
    res            = '0;
    pc_nxt         = pc;
    unique case (rtalu_pkg::alu_op_t'(op_sel))
      rtalu_pkg::OP_ADD: begin
        res.result   = sum_v;
        res.overflow = ~(a[MSB] ^ b[MSB]) & (a[MSB] ^ sum_v[MSB]);
      end
      rtalu_pkg::OP_SUB: begin
        res.result   = diff_v;
        res.overflow = (a[MSB] ^ b[MSB]) & (a[MSB] ^ diff_v[MSB]);
      end
      rtalu_pkg::OP_AND:  res.result = a & b;
      rtalu_pkg::OP_OR:   res.result = a | b;
      rtalu_pkg::OP_XOR:  res.result = a ^ b;
      rtalu_pkg::OP_NOR:  res.result = ~(a | b);
      rtalu_pkg::OP_NAND: res.result = ~(a & b);
      rtalu_pkg::OP_SLT: begin
        res.result = {{(rtalu_pkg::DATA_W-1){1'b0}}, ($signed(a) < $signed(b))};
      end
      rtalu_pkg::OP_SLL:  res.result = b << shamt;
      rtalu_pkg::OP_SRL:  res.result = b >> shamt;
      rtalu_pkg::OP_SRA:  res.result = $unsigned($signed(b) >>> shamt);
      rtalu_pkg::OP_JR: begin
        alu      = 1'b0;
        res.jump = 1'b1;
        pc_nxt   = a[rtalu_pkg::PC_W-1:0];
      end
      default: alu = 1'b0;
    endcase
    if (alu) begin
      res.zero_write = (dest == '0);
      res.write_en   = (dest != '0);
    end
  end

endmodule

FILE: design/r_type_alu_with_register_file.sv
// top level of the r-type alu with register file
//
// input channel (in_valid / in_ready) carries one decoded register-format
// instruction per transfer; output channel (out_valid / out_ready) carries
// one result per instruction, in order.
// an accepted instruction sits in the operand stage while the register file
// read completes, then passes through the alu and writes back, and its
// result is held in the output register.
// throughput is one instruction per cycle unless stalled; a result of
// one instruction is visible to the very next through the write bypass in
// the register file. the register file read (registered ram ports) and the
// single alu pass set the two-stage depth.
// when the receiver stalls, the output register holds its result, the
// operand stage holds one more instruction, and in_ready falls once both
// are full.
// reset clears the program counter and all register valid bits, so every
// register reads zero; no clearing pass is needed and the block is ready as
// soon as reset is released.
`include "assert_macros.svh"
module r_type_alu_with_register_file (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rtalu_pkg::OP_W-1:0]     in_op_select,
  input  logic [rtalu_pkg::IDX_W-1:0]    in_src_a_index,
  input  logic [rtalu_pkg::IDX_W-1:0]    in_src_b_index,
  input  logic [rtalu_pkg::IDX_W-1:0]    in_dest_index,
  input  logic [rtalu_pkg::IDX_W-1:0]    in_shift_amount,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rtalu_pkg::DATA_W-1:0]   out_result_value,
  output logic                           out_write_done,
  output logic                           out_overflow_flag,
  output logic                           out_zero_write_flag,
  output logic                           out_jump_taken,
  output logic [rtalu_pkg::PC_W-1:0]     out_next_pc
);

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [rtalu_pkg::OP_W-1:0]    s1_op_r;
  logic [rtalu_pkg::IDX_W-1:0]   s1_dest_r;
  logic [rtalu_pkg::IDX_W-1:0]   s1_shamt_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  rtalu_pkg::exec_res_t          res_r;
  logic [rtalu_pkg::PC_W-1:0]    pc_r;
  logic [rtalu_pkg::PC_W-1:0]    pc_nxt;
  logic [rtalu_pkg::DATA_W-1:0]  opnd_a;
  logic [rtalu_pkg::DATA_W-1:0]  opnd_b;
  rtalu_pkg::exec_res_t          exec_res;
  rtalu_pkg::rf_wr_t             rf_wr;
  logic                          accept;
  logic                          exec_go;

  assign exec_go  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || exec_go;
  assign accept   = in_valid && in_ready;

  assign rf_wr.en   = exec_go && exec_res.write_en;
  assign rf_wr.addr = s1_dest_r;
  assign rf_wr.data = exec_res.result;

  rtalu_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (in_src_a_index),
    .rd_addr_b (in_src_b_index),
    .wr        (rf_wr),
    .rd_data_a (opnd_a),
    .rd_data_b (opnd_b)
  );

  rtalu_exec u_exec (
    .op_sel (s1_op_r),
    .dest   (s1_dest_r),
    .shamt  (s1_shamt_r),
    .a      (opnd_a),
    .b      (opnd_b),
    .pc     (pc_r),
    .res    (exec_res),
    .pc_nxt (pc_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (exec_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        pc_r <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_op_select;
      s1_dest_r  <= in_dest_index;
      s1_shamt_r <= in_shift_amount;
    end
    if (exec_go) begin
      res_r <= exec_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = res_r.result;
  assign out_write_done      = res_r.write_en;
  assign out_overflow_flag   = res_r.overflow;
  assign out_zero_write_flag = res_r.zero_write;
  assign out_jump_taken      = res_r.jump;
  assign out_next_pc         = pc_r;

  `ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_r, "accepted item lost")
  `ASSERT_IMPLIES(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_ready, !in_ready,
    "input taken while both stages full")
  `ASSERT_NEXT(a_pc_only_on_jump, !(exec_go && exec_res.jump), $stable(pc_r),
    "program counter moved without jump")
  `ASSERT_IMPLIES(a_jump_no_write, exec_go && exec_res.jump, !rf_wr.en,
    "jump wrote the register file")

endmodule
